@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file ldtd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ldtd check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ldtd check failed");

`endif

@@ rtl/ldtd_pkg.sv @@
// Types and constants of the LZ delta tilemap decoder.
`default_nettype none

package ldtd_pkg;

	localparam int CNT_W   = 15;
	localparam int ENT_W   = 14;
	localparam int TOTAL_W = 13;
	localparam int TILE_W  = 16;
	localparam int CONT_BIT = 7;
	localparam logic [ENT_W-1:0] ENTRY_MAX = 14'h3fff;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_CTRL = 2'd0;
	localparam mode_t MODE_SYM  = 2'd1;
	localparam mode_t MODE_ADV  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_UNEXPECTED = 2'd1,
		ST_BAD_OFFSET = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_LEN0 = 3'd0,
		PH_LEN1 = 3'd1,
		PH_OFF0 = 3'd2,
		PH_OFF1 = 3'd3,
		PH_LIT  = 3'd4,
		PH_SYM  = 3'd5,
		PH_COPY = 3'd6
	} phase_t;

endpackage

`default_nettype wire

@@ rtl/ldtd_if.sv @@
// Valid/ready channel interfaces for decoder input items and results.
`default_nettype none

interface ldtd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  ctrl_byte;
	logic [15:0] symbol;

	modport source (output valid, output mode, output ctrl_byte, output symbol, input ready);
	modport sink (input valid, input mode, input ctrl_byte, input symbol, output ready);
endinterface

interface ldtd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] tile;
	logic        last;
	logic [1:0]  status;

	modport source (output valid, output tile, output last, output status, input ready);
	modport sink (input valid, input tile, input last, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/lz_delta_tilemap_decoder_top.sv @@
// Top level of the LZ delta tilemap decoder: parser, history memory and output register.
// Throughput: one input item per cycle, sustained, while results are taken.
// Each result is registered into stage 1 at its input transfer (history read into stage 1
//   at the transfer), and then into the output register as stage 1 moves on.
// Parser state, counters and pipeline valid bits clear on arst_n low.
// History memory is not cleared: an entry is only read after it has been written.
`default_nettype none

module lz_delta_tilemap_decoder_top #(
	parameter int HISTORY_DEPTH = 8192
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ldtd_in_if.sink                             in_ch,
	ldtd_out_if.source                          out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [ldtd_pkg::TOTAL_W-1:0]   cfg_data
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	// Address arithmetic width: holds wr_ptr + depth without overflow.
	localparam int XW = 17;

	// ---------------------------------------------------------------
	// Front stage: parser state, updated at each input transfer
	// ---------------------------------------------------------------
	ldtd_pkg::phase_t                phase_q, phase_d;
	logic [ldtd_pkg::CNT_W-1:0]      length_q, length_d;
	logic [ldtd_pkg::CNT_W-1:0]      offset_q, offset_d;
	logic [ldtd_pkg::CNT_W-1:0]      pending_q, pending_d;
	logic [ldtd_pkg::ENT_W-1:0]      entries_q, entries_d;
	logic [AW-1:0]                   wr_ptr_q, wr_ptr_d;
	logic [ldtd_pkg::TOTAL_W-1:0]    total_q;

	// Per-item decode
	logic                            res_f;     // item gives a result
	logic                            wr_f;      // item produces a delta
	logic                            copy_f;    // delta comes from history
	logic                            last_f;
	ldtd_pkg::status_t               status_f;
	logic [ldtd_pkg::CNT_W-1:0]      byte_lo;
	logic [ldtd_pkg::CNT_W-1:0]      byte_hi;
	logic [ldtd_pkg::CNT_W-1:0]      pend_dec;
	logic                            bad_off;
	logic [XW-1:0]                   wr_ext, off_ext, rd_full;
	logic [AW-1:0]                   raddr;
	logic                            in_fire;

	// ---------------------------------------------------------------
	// Stage 1: history read data is valid, delta formed, history written
	// ---------------------------------------------------------------
	logic                            valid_s1;
	logic                            wr_s1;
	logic                            copy_s1;
	logic                            last_s1;
	ldtd_pkg::status_t               status_s1;
	logic [ldtd_pkg::TILE_W-1:0]     sym_s1;
	logic [AW-1:0]                   waddr_s1;
	logic                            fwd_s1;
	logic [ldtd_pkg::TILE_W-1:0]     fwd_data_s1;
	logic [ldtd_pkg::TILE_W-1:0]     rdata_q;
	logic [ldtd_pkg::TILE_W-1:0]     delta_s1;
	logic                            adv_s1;

	logic [ldtd_pkg::TILE_W-1:0]     hist_q [HISTORY_DEPTH];
	logic [ldtd_pkg::TILE_W-1:0]     sum_q;

	// Output register
	logic                            out_valid_q;
	logic [ldtd_pkg::TILE_W-1:0]     tile_q;
	logic                            last_q;
	ldtd_pkg::status_t               status_q;

	// Stage 1 moves on when the output register is free or being emptied;
	// a new item enters whenever stage 1 is empty or moving on.
	assign adv_s1      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign in_fire     = in_ch.valid && in_ch.ready;

	assign byte_lo  = {8'd0, in_ch.ctrl_byte[ldtd_pkg::CONT_BIT-1:0]};
	assign byte_hi  = {in_ch.ctrl_byte, 7'd0};
	assign pend_dec = pending_q - ldtd_pkg::CNT_W'(1);

	// Copy source: wr_ptr - offset, wrapped into the history ring.
	assign wr_ext  = XW'(wr_ptr_q);
	assign off_ext = XW'(offset_q);
	assign rd_full = (wr_ext >= off_ext) ? (wr_ext - off_ext)
	                                     : (wr_ext + XW'(HISTORY_DEPTH) - off_ext);
	assign raddr   = rd_full[AW-1:0];

	assign bad_off = (offset_q == '0)
	              || (off_ext > XW'(entries_q))
	              || (off_ext > XW'(HISTORY_DEPTH));

	// Next parser state and per-item decode, applied at an input transfer.
	always_comb begin
		phase_d   = phase_q;
		length_d  = length_q;
		offset_d  = offset_q;
		pending_d = pending_q;
		entries_d = entries_q;
		wr_ptr_d  = wr_ptr_q;
		res_f     = 1'b0;
		wr_f      = 1'b0;
		copy_f    = 1'b0;
		status_f  = ldtd_pkg::ST_OK;

		if (in_ch.mode == ldtd_pkg::MODE_CTRL && (phase_q == ldtd_pkg::PH_LEN0
		    || phase_q == ldtd_pkg::PH_LEN1 || phase_q == ldtd_pkg::PH_OFF0
		    || phase_q == ldtd_pkg::PH_OFF1)) begin
			// Header bytes: no result.
			unique case (phase_q)
				ldtd_pkg::PH_LEN0: begin
					length_d = byte_lo;
					phase_d  = in_ch.ctrl_byte[ldtd_pkg::CONT_BIT] ? ldtd_pkg::PH_LEN1
					                                                : ldtd_pkg::PH_OFF0;
				end
				ldtd_pkg::PH_LEN1: begin
					length_d = length_q + byte_hi;
					phase_d  = ldtd_pkg::PH_OFF0;
				end
				ldtd_pkg::PH_OFF0: begin
					offset_d = byte_lo;
				end
				default: begin
					offset_d = offset_q + byte_hi;
				end
			endcase
			// Offset complete: pick literal run, empty run or symbol-plus-copy.
			if ((phase_q == ldtd_pkg::PH_OFF0 && !in_ch.ctrl_byte[ldtd_pkg::CONT_BIT])
			    || phase_q == ldtd_pkg::PH_OFF1) begin
				if (length_q == '0) begin
					pending_d = offset_d;
					phase_d   = (offset_d == '0) ? ldtd_pkg::PH_LEN0 : ldtd_pkg::PH_LIT;
				end else begin
					phase_d = ldtd_pkg::PH_SYM;
				end
			end else if (phase_q == ldtd_pkg::PH_OFF0) begin
				phase_d = ldtd_pkg::PH_OFF1;
			end
		end else if (in_ch.mode == ldtd_pkg::MODE_SYM && phase_q == ldtd_pkg::PH_LIT) begin
			res_f     = 1'b1;
			wr_f      = 1'b1;
			pending_d = pend_dec;
			if (pend_dec == '0) begin
				phase_d = ldtd_pkg::PH_LEN0;
			end
		end else if (in_ch.mode == ldtd_pkg::MODE_SYM && phase_q == ldtd_pkg::PH_SYM) begin
			res_f     = 1'b1;
			wr_f      = 1'b1;
			pending_d = length_q;
			phase_d   = ldtd_pkg::PH_COPY;
		end else if (in_ch.mode == ldtd_pkg::MODE_ADV && phase_q == ldtd_pkg::PH_COPY) begin
			res_f = 1'b1;
			if (bad_off) begin
				// Drop the rest of the copy.
				status_f  = ldtd_pkg::ST_BAD_OFFSET;
				pending_d = '0;
				phase_d   = ldtd_pkg::PH_LEN0;
			end else begin
				wr_f      = 1'b1;
				copy_f    = 1'b1;
				pending_d = pend_dec;
				if (pend_dec == '0) begin
					phase_d = ldtd_pkg::PH_LEN0;
				end
			end
		end else begin
			// Wrong kind for this phase: report, change nothing.
			res_f    = 1'b1;
			status_f = ldtd_pkg::ST_UNEXPECTED;
		end

		if (wr_f) begin
			wr_ptr_d  = (wr_ptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			entries_d = (entries_q < ldtd_pkg::ENTRY_MAX) ? entries_q + ldtd_pkg::ENT_W'(1)
			                                              : entries_q;
		end
		last_f = wr_f && (total_q != '0) && (entries_d == {1'b0, total_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ldtd_pkg::PH_LEN0;
			length_q  <= '0;
			offset_q  <= '0;
			pending_q <= '0;
			entries_q <= '0;
			wr_ptr_q  <= '0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			length_q  <= length_d;
			offset_q  <= offset_d;
			pending_q <= pending_d;
			entries_q <= entries_d;
			wr_ptr_q  <= wr_ptr_d;
		end
	end

	// Entry count register; the user must write it only while the decoder is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------
	// History memory: one read port at the input transfer, one write
	// port as stage 1 moves on. A copy whose source is the entry being
	// written in the same cycle takes the write data instead.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv_s1 && wr_s1) begin
			hist_q[waddr_s1] <= delta_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && copy_f) begin
			rdata_q <= hist_q[raddr];
		end
	end

	assign delta_s1 = !copy_s1 ? sym_s1 : (fwd_s1 ? fwd_data_s1 : rdata_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= res_f;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			wr_s1       <= wr_f;
			copy_s1     <= copy_f;
			last_s1     <= last_f;
			status_s1   <= status_f;
			sym_s1      <= in_ch.symbol;
			waddr_s1    <= wr_ptr_q;
			fwd_s1      <= adv_s1 && wr_s1 && (waddr_s1 == raddr);
			fwd_data_s1 <= delta_s1;
		end
	end

	// Running tile number advances in result order as stage 1 moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv_s1 && wr_s1) begin
			sum_q <= sum_q + delta_s1;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tile_q   <= wr_s1 ? (sum_q + delta_s1) : sum_q;
			last_q   <= last_s1;
			status_q <= status_s1;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.tile   = tile_q;
	assign out_ch.last   = last_q;
	assign out_ch.status = status_q;

endmodule

`default_nettype wire

@@ rtl/ldtd_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ldtd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_tile,
	input wire logic        out_last,
	input wire logic [1:0]  out_status
);

	// Stalled result holds.
	`ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_tile) && $stable(out_last) && $stable(out_status))

	// Error results never mark the final entry.
	`ASSERT_IMP(a_err_not_last, out_valid && out_status != ldtd_pkg::ST_OK, !out_last)

	// Only defined status codes leave the block.
	`ASSERT_IMP(a_status_code, out_valid, out_status == ldtd_pkg::ST_OK || out_status == ldtd_pkg::ST_UNEXPECTED || out_status == ldtd_pkg::ST_BAD_OFFSET)

	// An error result right after another result repeats its tile number.
	`ASSERT_NXT(a_err_tile, out_valid && out_ready, !(out_valid && out_ready && out_status != ldtd_pkg::ST_OK) || out_tile == $past(out_tile))

endmodule

bind lz_delta_tilemap_decoder_top ldtd_checker u_ldtd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_tile   (out_ch.tile),
	.out_last   (out_ch.last),
	.out_status (out_ch.status)
);

`default_nettype wire
